FILE: rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg: shared definitions for the melody tone sequencer
// Song ROM contents, timing constants and the control/status bundles that
// pass between the sequencer controller and its datapath.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned SONG_COUNT = 3;
  localparam int unsigned MAX_NOTES  = 8;
  localparam int unsigned TONE_COUNT = 10;

  localparam logic [16:0] TAIL_MS     = 17'd2;
  localparam logic [16:0] TIMER_MAX   = 17'h10000;
  localparam logic [9:0]  RELOAD_IDLE = 10'd999;
  localparam logic [9:0]  CMP_IDLE_LO = 10'd1000;
  localparam logic [6:0]  VOLUME_MAX  = 7'd100;
  localparam logic [7:0]  PULSE_DIV   = 8'd200;
  // x / 200 equals ((x >> 3) * PULSE_RECIP) >> 19 for every 17-bit x.
  localparam logic [14:0] PULSE_RECIP = 15'd20972;

  // Configuration register indexes.
  localparam logic [1:0] CFG_VOLUME      = 2'd0;
  localparam logic [1:0] CFG_ENABLE      = 2'd1;
  localparam logic [1:0] CFG_ACTIVE_HIGH = 2'd2;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic mul;
    logic div_start;
    logic set_cmp;
    logic load_out;
  } mts_cmd_t;

  typedef struct packed {
    logic note_req;
    logic div_done;
  } mts_status_t;

  // Number of notes in a song.
  function automatic logic [3:0] song_len(input logic [1:0] s);
    logic [3:0] n;
    case (s)
      2'd0:    n = 4'd5;
      2'd1:    n = 4'd1;
      2'd2:    n = 4'd1;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // Tone number of a note; zero is a rest.
  function automatic logic [3:0] song_tone(input logic [1:0] s, input logic [2:0] n);
    logic [3:0] t;
    case ({s, n})
      5'b00_001: t = 4'd1;
      5'b00_010: t = 4'd5;
      5'b00_011: t = 4'd4;
      5'b00_100: t = 4'd8;
      5'b01_000: t = 4'd8;
      5'b10_000: t = 4'd10;
      default:   t = 4'd0;
    endcase
    return t;
  endfunction

  // Rounded note duration in ms from beats and tempo, at least 1.
  function automatic logic [16:0] note_ms(input logic [1:0] s, input logic [2:0] n);
    logic [16:0] d;
    case ({s, n})
      5'b00_000, 5'b00_001, 5'b00_010, 5'b00_011, 5'b00_100: d = 17'd158;
      5'b01_000: d = 17'd63;
      5'b10_000: d = 17'd100;
      default:   d = 17'd1;
    endcase
    return d;
  endfunction

  // One tenth of the note duration, clamped to 3..10 and kept below the note.
  function automatic logic [16:0] gap_base(input logic [1:0] s, input logic [2:0] n);
    logic [16:0] g;
    case ({s, n})
      5'b00_000, 5'b00_001, 5'b00_010, 5'b00_011, 5'b00_100: g = 17'd10;
      5'b01_000: g = 17'd6;
      5'b10_000: g = 17'd10;
      default:   g = 17'd0;
    endcase
    return g;
  endfunction

  // A gap follows a note when it and the next note both have a tone.
  function automatic logic gap_need(input logic [1:0] s, input logic [2:0] n);
    logic [3:0] nxt;
    nxt = {1'b0, n} + 4'd1;
    return (nxt < song_len(s)) && (song_tone(s, n) != 4'd0) &&
           (song_tone(s, n + 3'd1) != 4'd0);
  endfunction

  // PWM period in microseconds for tones 1..10.
  function automatic logic [9:0] tone_top(input logic [3:0] t);
    logic [9:0] p;
    case (t)
      4'd1:    p = 10'd956;
      4'd2:    p = 10'd851;
      4'd3:    p = 10'd758;
      4'd4:    p = 10'd716;
      4'd5:    p = 10'd638;
      4'd6:    p = 10'd568;
      4'd7:    p = 10'd506;
      4'd8:    p = 10'd478;
      4'd9:    p = 10'd239;
      4'd10:   p = 10'd225;
      default: p = 10'd2;
    endcase
    return p;
  endfunction

  // Timer load: zero becomes one, long values saturate.
  function automatic logic [16:0] timer_clip(input logic [16:0] ms);
    logic [16:0] r;
    if (ms == 17'd0) begin
      r = 17'd1;
    end else if (ms > TIMER_MAX) begin
      r = TIMER_MAX;
    end else begin
      r = ms;
    end
    return r;
  endfunction

endpackage

FILE: rtl/mts_div.sv
// ----------------------------------------------------------------------------
// mts_div: division by the pulse scale constant
// Divides by 200 with a shift and a reciprocal multiply; done pulses in the
// cycle after start, with the quotient registered.
// ----------------------------------------------------------------------------
module mts_div import mts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] dividend,
  output logic        done,
  output logic [16:0] quotient
);

  logic [28:0] scaled;
  logic [9:0]  quo;

  // Dropping the three low bits divides by 8; the reciprocal then divides the
  // 14-bit remainder of the dividend by 25 exactly.
  assign scaled = 29'(dividend[16:3]) * 29'(PULSE_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= scaled[28:19];
    end
  end

  assign quotient = {7'd0, quo};

endmodule

FILE: rtl/mts_datapath.sv
// ----------------------------------------------------------------------------
// mts_datapath: sequencing state, note timing and PWM values
// Holds the configuration, song position and note timer, evaluates one item
// on command and forms the volume-scaled compare through the divider.
// ----------------------------------------------------------------------------
module mts_datapath import mts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  mts_cmd_t    cmd,
  output mts_status_t status,
  input  logic        action,
  input  logic [1:0]  song,
  input  logic        cfg_fire,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  output logic [9:0]  pwm_reload,
  output logic [9:0]  pwm_compare,
  output logic        playing,
  output logic        play_done,
  output logic [2:0]  note_position
);

  logic [6:0]  volume;
  logic        enable;
  logic        active_high;
  logic        busy;
  logic [1:0]  current_song;
  logic [2:0]  note_counter;
  logic [16:0] time_left;
  logic        gap_pending;
  logic        tail_pending;
  logic [9:0]  reload;
  logic [9:0]  compare;
  logic        in_action;
  logic [1:0]  in_song;
  logic        done;
  logic [16:0] product;

  logic        busy_next;
  logic [1:0]  song_next;
  logic [2:0]  nc_next;
  logic [16:0] time_next;
  logic        gap_next;
  logic        tail_next;
  logic [9:0]  reload_next;
  logic [9:0]  compare_next;
  logic        done_next;

  logic        do_start;
  logic [1:0]  st_song;
  logic [2:0]  st_idx;
  logic [3:0]  st_tone;
  logic        st_rest;
  logic [16:0] st_gap;
  logic [16:0] time_dec;
  logic [2:0]  nc_inc;
  logic        last_note;
  logic        cur_need;
  logic [9:0]  top;
  logic        div_done;
  logic [16:0] quotient;
  logic [9:0]  pulse;

  assign time_dec  = (time_left != 17'd0) ? time_left - 17'd1 : time_left;
  assign nc_inc    = note_counter + 3'd1;
  assign last_note = ({1'b0, note_counter} + 4'd1) >= song_len(current_song);
  assign cur_need  = gap_need(current_song, note_counter) && (volume != 7'd0);

  assign st_tone = song_tone(st_song, st_idx);
  assign st_rest = (st_tone == 4'd0) || (st_tone > 4'(TONE_COUNT)) || (volume == 7'd0);
  assign st_gap  = (gap_need(st_song, st_idx) && (volume != 7'd0)) ?
                   gap_base(st_song, st_idx) : 17'd0;

  always_comb begin
    busy_next    = busy;
    song_next    = current_song;
    nc_next      = note_counter;
    time_next    = time_left;
    gap_next     = gap_pending;
    tail_next    = tail_pending;
    reload_next  = reload;
    compare_next = compare;
    done_next    = 1'b0;
    do_start     = 1'b0;
    st_song      = current_song;
    st_idx       = nc_inc;
    if (in_action) begin
      if (!busy && (volume != 7'd0) && enable && (in_song < 2'(SONG_COUNT)) &&
          (song_len(in_song) != 4'd0)) begin
        song_next = in_song;
        nc_next   = 3'd0;
        gap_next  = 1'b0;
        tail_next = 1'b0;
        busy_next = 1'b1;
        do_start  = 1'b1;
        st_song   = in_song;
        st_idx    = 3'd0;
      end
    end else if (busy) begin
      time_next = time_dec;
      if (time_dec == 17'd0) begin
        if (gap_pending) begin
          gap_next = 1'b0;
          nc_next  = nc_inc;
          do_start = 1'b1;
        end else if (last_note) begin
          if (!tail_pending && (song_tone(current_song, note_counter) != 4'd0) &&
              (volume != 7'd0)) begin
            tail_next = 1'b1;
            time_next = TAIL_MS;
          end else begin
            if (active_high) begin
              compare_next = 10'd0;
            end else begin
              reload_next  = RELOAD_IDLE;
              compare_next = CMP_IDLE_LO;
            end
            busy_next = 1'b0;
            nc_next   = 3'd0;
            time_next = 17'd0;
            gap_next  = 1'b0;
            tail_next = 1'b0;
            done_next = 1'b1;
          end
        end else begin
          tail_next = 1'b0;
          if (cur_need) begin
            gap_next = 1'b1;
            if (active_high) begin
              compare_next = 10'd0;
            end else begin
              reload_next  = RELOAD_IDLE;
              compare_next = CMP_IDLE_LO;
            end
            time_next = timer_clip(gap_base(current_song, note_counter));
          end else begin
            nc_next  = nc_inc;
            do_start = 1'b1;
          end
        end
      end
    end
    if (do_start) begin
      if (st_rest) begin
        reload_next  = RELOAD_IDLE;
        compare_next = active_high ? 10'd0 : CMP_IDLE_LO;
      end else begin
        reload_next = tone_top(st_tone) - 10'd1;
      end
      time_next = timer_clip(note_ms(st_song, st_idx) - st_gap);
    end
  end

  assign status.note_req = do_start && !st_rest;
  assign status.div_done = div_done;

  assign top   = reload + 10'd1;
  assign pulse = quotient[9:0];

  mts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (product),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      volume       <= VOLUME_MAX;
      enable       <= 1'b0;
      active_high  <= 1'b1;
      busy         <= 1'b0;
      current_song <= '0;
      note_counter <= '0;
      time_left    <= '0;
      gap_pending  <= 1'b0;
      tail_pending <= 1'b0;
      reload       <= RELOAD_IDLE;
      compare      <= 10'd0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_VOLUME: begin
            if (cfg_data <= VOLUME_MAX) begin
              volume <= cfg_data;
            end
          end
          CFG_ENABLE: begin
            enable <= cfg_data[0];
            if (active_high) begin
              compare <= 10'd0;
            end else begin
              reload  <= RELOAD_IDLE;
              compare <= CMP_IDLE_LO;
            end
            if (!cfg_data[0]) begin
              busy         <= 1'b0;
              note_counter <= '0;
              time_left    <= '0;
              gap_pending  <= 1'b0;
              tail_pending <= 1'b0;
            end
          end
          CFG_ACTIVE_HIGH: active_high <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.eval) begin
        busy         <= busy_next;
        current_song <= song_next;
        note_counter <= nc_next;
        time_left    <= time_next;
        gap_pending  <= gap_next;
        tail_pending <= tail_next;
        reload       <= reload_next;
        compare      <= compare_next;
      end
      if (cmd.set_cmp) begin
        compare <= active_high ? pulse : top - pulse;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_action <= action;
      in_song   <= song;
    end
    if (cmd.eval) begin
      done <= done_next;
    end
    if (cmd.mul) begin
      product <= 17'(top) * 17'(volume);
    end
    if (cmd.load_out) begin
      pwm_reload    <= reload;
      pwm_compare   <= compare;
      playing       <= busy;
      play_done     <= done;
      note_position <= note_counter;
    end
  end

`ifndef SYNTHESIS
  a_busy_enabled : assert property (@(posedge clk) disable iff (rst)
    busy |-> enable)
    else $error("song in progress while disabled");

  a_idle_clean : assert property (@(posedge clk) disable iff (rst)
    !busy |-> (note_counter == 3'd0) && !gap_pending && !tail_pending)
    else $error("sequencing state left over while idle");

  a_pos_in_song : assert property (@(posedge clk) disable iff (rst)
    busy |-> ({1'b0, note_counter} < song_len(current_song)))
    else $error("note position beyond song length");

  a_timer_armed : assert property (@(posedge clk) disable iff (rst)
    busy |-> (time_left != 17'd0))
    else $error("note timer empty while playing");

  a_gap_tail : assert property (@(posedge clk) disable iff (rst)
    gap_pending |-> !tail_pending)
    else $error("gap and tail pending together");
`endif

endmodule

FILE: rtl/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl: item sequencing controller
// Steps each accepted item through evaluation, the compare computation when
// a note starts, and the output register.
// ----------------------------------------------------------------------------
module mts_ctrl import mts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output mts_cmd_t    cmd,
  input  mts_status_t status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = status.note_req ? S_MUL : S_OUT;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (status.div_done) begin
          cmd.set_cmp = 1'b1;
          state_next  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_to_eval : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EVAL))
    else $error("accepted item not evaluated next");

  a_div_to_out : assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) && status.div_done |=> (state == S_OUT))
    else $error("compare result not taken");

  a_load_sets_valid : assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid && (state == S_IDLE))
    else $error("result register not presented");
`endif

endmodule

FILE: rtl/melody_tone_sequencer.sv
// ----------------------------------------------------------------------------
// melody_tone_sequencer: fixed-melody buzzer sequencer
// Plays songs from a built-in ROM on a PWM: play requests start a song,
// millisecond ticks count each note down, and every item returns the PWM
// reload and compare together with the song status.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   -------   -------------------   -----------------------------------------
//   in        in_valid/in_ready     action, song
//   out       out_valid/out_ready   pwm_reload, pwm_compare, playing,
//                                   play_done, note_position
//   cfg       cfg_valid/cfg_ready   cfg_index, cfg_data
//
// Each input item produces exactly one output item. An item that starts a
// sounding note passes through evaluation, a multiply of the period by the
// volume, a scale by 1/200 that loads the compare, and then the output
// register; every other item goes from evaluation to the output register.
// One item is in work at a time; the next is accepted once the result is in
// the output register, which holds it until the consumer takes it.
// Reset (rst, synchronous) returns volume 100, disabled, active-high polarity,
// idle, reload 999 and compare 0. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module melody_tone_sequencer import mts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [1:0] song,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [9:0] pwm_reload,
  output logic [9:0] pwm_compare,
  output logic       playing,
  output logic       play_done,
  output logic [2:0] note_position,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  mts_cmd_t    cmd;
  mts_status_t status;

  // Configuration registers sit in the datapath and are written whenever a write
  // is presented, so the write channel never stalls.
  assign cfg_ready = 1'b1;

  // The controller walks each item through evaluate and output-register load,
  // with multiply and divide between them when an item starts a sounding note.
  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath owns the song position, note timer, PWM values and the
  // result register.
  mts_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .action        (action),
    .song          (song),
    .cfg_fire      (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pwm_reload    (pwm_reload),
    .pwm_compare   (pwm_compare),
    .playing       (playing),
    .play_done     (play_done),
    .note_position (note_position)
  );

endmodule
